### sv/itec_pkg.sv
// Shared types and constants of the ion-tail exponential correction block.
// Holds the fixed-point widths, the register index codes and the back-end state type.
// No dependencies.
package itec_pkg;

    // Fixed-point widths
    localparam int SUM_W       = 32;  // decaying sum, 1/16 ADC
    localparam int GAIN_W      = 16;  // Q0.16 gains
    localparam int CORR_W      = 28;  // correction term, ADC
    localparam int OUT_W       = 16;  // corrected charge, signed
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // 1.625 ADC in 1/16 ADC units
    localparam logic [SUM_W-1:0] SUM_THRESHOLD = 32'd26;

    // Register index codes
    localparam logic [CFG_INDEX_W-1:0] REG_AMP_GAIN      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_SLOPE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGN_NEGATIVE = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0] amp_gain;
        logic [GAIN_W-1:0] tail_slope;
        logic              sign_negative;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_GAP,
        BK_CORR,
        BK_FINAL
    } back_state_t;

endpackage

### sv/itec_front.sv
// Front end: accepts samples, tracks the previous row, pad and time bin,
// and classifies each sample into a clear flag and a gap-decay step count.
// Depends on itec_pkg.
module itec_front
    import itec_pkg::*;
#(
    parameter int TIME_BITS   = 20,
    parameter int CHARGE_BITS = 14
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        row,
    input  logic [7:0]                        pad,
    input  logic [TIME_BITS-1:0]              time_bin,
    input  logic [CHARGE_BITS-1:0]            charge,
    output logic                              push_valid,
    input  logic                              push_ready,
    output logic [CHARGE_BITS+TIME_BITS:0]    push_entry  // {charge, gap, clear}
);

    logic                 have_prev_reg;
    logic [7:0]           prev_row_reg;
    logic [7:0]           prev_pad_reg;
    logic [TIME_BITS-1:0] prev_time_reg;
    logic                 new_pad;
    logic [TIME_BITS-1:0] gap;
    logic                 fire;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign fire       = in_valid && push_ready;

    // Classify: a new pad clears the sum, otherwise count the missing bins
    always_comb
    begin
        new_pad = !have_prev_reg || (row != prev_row_reg) || (pad != prev_pad_reg);
        if (new_pad || (time_bin <= prev_time_reg))
        begin
            gap = '0;
        end
        else
        begin
            gap = time_bin - prev_time_reg - TIME_BITS'(1);
        end
    end

    assign push_entry = {charge, gap, new_pad};

    // Remember the last transferred sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_row_reg  <= '0;
            prev_pad_reg  <= '0;
            prev_time_reg <= '0;
        end
        else if (fire)
        begin
            have_prev_reg <= 1'b1;
            prev_row_reg  <= row;
            prev_pad_reg  <= pad;
            prev_time_reg <= time_bin;
        end
    end

endmodule

### sv/itec_queue.sv
// Two-entry queue between the front end and the back end.
// Lets either side stall on its own. Depends on itec_pkg.
module itec_queue
    import itec_pkg::*;
#(
    parameter int WIDTH = 35
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Store payload
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### sv/itec_back.sv
// Back end: runs the gap decay loop on the shared decay multiplier, forms the
// correction, saturates the result and accumulates the charge into the sum.
// Depends on itec_pkg.
module itec_back
    import itec_pkg::*;
#(
    parameter int TIME_BITS   = 20,
    parameter int CHARGE_BITS = 14
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  logic [CHARGE_BITS+TIME_BITS:0] pop_entry,  // {charge, gap, clear}
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [OUT_W-1:0]               out_data
);

    localparam int V_W = ((CHARGE_BITS > CORR_W) ? CHARGE_BITS : CORR_W) + 2;
    localparam logic signed [V_W-1:0] V_MAX = V_W'(32767);
    localparam logic signed [V_W-1:0] V_MIN = V_W'(-32768);

    back_state_t            state_reg, state_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SUM_W-1:0]       work_reg, work_next;
    logic [TIME_BITS-1:0]   cnt_reg, cnt_next;
    logic [CHARGE_BITS-1:0] q_reg, q_next;
    logic [GAIN_W-1:0]      k_reg;
    logic [CORR_W-1:0]      corr_reg, corr_next;
    logic [SUM_W-1:0]       acc_reg, acc_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]       out_data_reg, out_data_next;

    logic                   e_clear;
    logic [TIME_BITS-1:0]   e_gap;
    logic [CHARGE_BITS-1:0] e_charge;
    logic [SUM_W-1:0]       decay_in;
    logic [SUM_W+GAIN_W-1:0] decay_prod;
    logic [SUM_W-1:0]       decay_val;
    logic                   decay_low;
    logic [2*GAIN_W:0]      k_prod;
    logic [SUM_W+GAIN_W-1:0] corr_prod;
    logic [SUM_W:0]         acc_sum;
    logic signed [V_W-1:0]  q_ext;
    logic signed [V_W-1:0]  corr_ext;
    logic signed [V_W-1:0]  v;
    logic                   out_free;

    assign {e_charge, e_gap, e_clear} = pop_entry;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Shared decay multiplier: gap loop in GAP, accumulated sum in FINAL
    assign decay_in   = (state_reg == BK_GAP) ? work_reg : acc_reg;
    assign decay_prod = decay_in * cfg.tail_slope;
    assign decay_val  = decay_prod[SUM_W+GAIN_W-1:GAIN_W];
    assign decay_low  = (decay_val < SUM_THRESHOLD);

    // Gain k = amp * (1 - slope), refreshed every cycle from the registers
    assign k_prod = cfg.amp_gain * ({1'b1, {GAIN_W{1'b0}}} - {1'b0, cfg.tail_slope});

    // Correction and saturated accumulation
    assign corr_prod = k_reg * work_reg;
    assign acc_sum   = {1'b0, work_reg} + (SUM_W+1)'({q_reg, 4'b0000});

    // Signed result before saturation
    always_comb
    begin
        q_ext    = signed'(V_W'(q_reg));
        corr_ext = signed'(V_W'(corr_reg));
        if (cfg.sign_negative)
        begin
            v = q_ext - corr_ext;
        end
        else
        begin
            v = q_ext + corr_ext;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = (e_gap != '0) ? BK_GAP : BK_CORR;
                end
            end
            BK_GAP:
            begin
                if (decay_low || (cnt_reg == TIME_BITS'(1)))
                begin
                    state_next = BK_CORR;
                end
            end
            BK_CORR:
            begin
                state_next = BK_FINAL;
            end
            BK_FINAL:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        pop_ready      = 1'b0;
        sum_next       = sum_reg;
        work_next      = work_reg;
        cnt_next       = cnt_reg;
        q_next         = q_reg;
        corr_next      = corr_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                // Load the next queued sample
                pop_ready = 1'b1;
                work_next = e_clear ? '0 : sum_reg;
                cnt_next  = e_gap;
                q_next    = e_charge;
            end
            BK_GAP:
            begin
                // Decay once per missing bin; drop to zero under threshold
                work_next = decay_low ? '0 : decay_val;
                cnt_next  = decay_low ? '0 : (cnt_reg - TIME_BITS'(1));
            end
            BK_CORR:
            begin
                corr_next = corr_prod[SUM_W+GAIN_W-1:20];
                acc_next  = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
            end
            BK_FINAL:
            begin
                // Deliver the result and commit the decayed sum
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sum_next       = decay_val;
                    if (v > V_MAX)
                    begin
                        out_data_next = OUT_W'(V_MAX);
                    end
                    else if (v < V_MIN)
                    begin
                        out_data_next = OUT_W'(V_MIN);
                    end
                    else
                    begin
                        out_data_next = v[OUT_W-1:0];
                    end
                end
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        cnt_reg      <= cnt_next;
        q_reg        <= q_next;
        k_reg        <= k_prod[2*GAIN_W-1:GAIN_W];
        corr_reg     <= corr_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

endmodule

### sv/ion_tail_exponential_correction.sv
// Top level of the ion-tail exponential correction block.
// Holds the configuration registers and connects front end, queue and back end.
// Depends on itec_pkg, itec_front, itec_queue, itec_back.
//
// Usage:
//   s_axis carries samples ordered by row, pad and rising time bin; m_axis
//   returns one corrected charge per sample, in order. The cfg channel writes
//   amp_gain (index 0), tail_slope (1) and sign_negative (2); it is always
//   ready, other indexes are ignored. Write it only while no sample is in flight.
//   After the queue, the back end takes each sample through load, one gap
//   decay step per missing time bin, correction multiply, and result and sum
//   decay; the gap loop ends early once the sum falls under 1.625 ADC. The
//   back end takes a new sample only once it is through with the last one,
//   and its single decay multiplier serves both the gap loop and sum decay.
//   A two-entry queue decouples input from processing, so samples keep being
//   transferred while the back end works or m_axis stalls; the result register
//   holds its value until transferred. Up to four samples can be in flight.
//   Reset clears the registers to zero, forgets the previous pad and empties
//   the queue and the result register.
module ion_tail_exponential_correction
    import itec_pkg::*;
#(
    parameter int TIME_BITS   = 20,
    parameter int CHARGE_BITS = 14
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // row, pad, time_bin, charge from bit 0 up, zero padded to whole bytes
    input  logic [((16+TIME_BITS+CHARGE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // corrected_charge
    output logic [OUT_W-1:0]       m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ENTRY_W = CHARGE_BITS + TIME_BITS + 1;

    cfg_t                 cfg_reg;
    logic                 push_valid;
    logic                 push_ready;
    logic [ENTRY_W-1:0]   push_entry;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [ENTRY_W-1:0]   pop_entry;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_AMP_GAIN:      cfg_reg.amp_gain      <= cfg_data;
                REG_TAIL_SLOPE:    cfg_reg.tail_slope    <= cfg_data;
                REG_SIGN_NEGATIVE: cfg_reg.sign_negative <= cfg_data[0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    itec_front #(
        .TIME_BITS   (TIME_BITS),
        .CHARGE_BITS (CHARGE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .row        (s_axis_tdata[7:0]),
        .pad        (s_axis_tdata[15:8]),
        .time_bin   (s_axis_tdata[16 +: TIME_BITS]),
        .charge     (s_axis_tdata[16+TIME_BITS +: CHARGE_BITS]),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    itec_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_entry),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_entry)
    );

    itec_back #(
        .TIME_BITS   (TIME_BITS),
        .CHARGE_BITS (CHARGE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

### sv/itec_checker.sv
// Port-level checks for the ion-tail exponential correction block, with its bind.
// Tracks samples in flight from the stream transfers.
// Depends on itec_pkg and binds to ion_tail_exponential_correction.
module itec_checker
    import itec_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    logic [3:0] inflight_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Count samples transferred in but not yet out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            inflight_reg <= inflight_reg + 4'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            inflight_reg <= inflight_reg - 4'd1;
        end
    end

    // Hold a stalled result
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No result without a sample behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> inflight_reg != 4'd0)
        else $error("result shown with no sample in flight");

    // Queue, back end and result register bound the samples in flight
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 4'd4)
        else $error("too many samples in flight");

endmodule

bind ion_tail_exponential_correction itec_checker u_itec_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/ion_tail_exponential_correction_test.sv
// Self-checking testbench for the ion-tail exponential correction block.
// Drives pad samples and register writes, predicts each corrected charge in place.
// Depends on itec_pkg and ion_tail_exponential_correction.
`timescale 1ns / 100ps

module ion_tail_exponential_correction_test;
    import itec_pkg::*;

    localparam int TIME_BITS    = 20;
    localparam int CHARGE_BITS  = 14;
    localparam int DATA_W       = ((16 + TIME_BITS + CHARGE_BITS + 7) / 8) * 8;
    localparam int TIME_MAX     = (1 << TIME_BITS) - 1;
    localparam int CHARGE_MAX   = (1 << CHARGE_BITS) - 1;
    localparam int RANDOM_ITEMS = 480;
    localparam int PHASE_ITEMS  = 110;
    localparam int SOAK_ITEMS   = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam longint unsigned SUM_CEILING = 64'hFFFF_FFFF;

    // Index past the last register; writes to it must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        bit                     reconfig;
        logic [GAIN_W-1:0]      amp;
        logic [GAIN_W-1:0]      slope;
        bit                     neg;
        logic [7:0]             row;
        logic [7:0]             pad;
        logic [TIME_BITS-1:0]   tbin;
        logic [CHARGE_BITS-1:0] charge;
        bit                     known;
        logic [OUT_W-1:0]       result;
    } vector_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // row, pad, time_bin, charge from bit 0 up, zero padded to whole bytes
    logic [DATA_W-1:0]      s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // corrected_charge
    logic [OUT_W-1:0]       m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor copy of registers and per-pad state
    logic [GAIN_W-1:0]      cfg_amp;
    logic [GAIN_W-1:0]      cfg_slope;
    bit                     cfg_neg;
    bit                     pad_open;
    logic [7:0]             last_row;
    logic [7:0]             last_pad;
    longint unsigned        last_tbin;
    longint unsigned        tail_sum;

    logic [OUT_W-1:0]       pending_corrected[$];
    vector_t                vectors[$];
    logic [OUT_W-1:0]       want_charge;
    int                     mismatches;
    int                     cycle_count;
    int                     hold_left;
    bit                     hold_done;
    bit                     hold_request;
    bit                     steady_run;

    ion_tail_exponential_correction #(
        .TIME_BITS   (TIME_BITS),
        .CHARGE_BITS (CHARGE_BITS)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("ion_tail_exponential_correction_test: FAIL");
            $finish;
        end
    end

    // Corrected charge of one sample; advances the per-pad decaying sum
    function automatic logic [OUT_W-1:0] predict_corrected(input logic [7:0] r,
                                                           input logic [7:0] p,
                                                           input logic [TIME_BITS-1:0] t,
                                                           input logic [CHARGE_BITS-1:0] q);
        longint unsigned sum;
        longint unsigned tt;
        longint unsigned gain;
        longint unsigned corr;
        longint          value;
        sum = tail_sum;
        tt  = t;
        // New pad clears the sum and skips the gap decay
        if (!pad_open || r != last_row || p != last_pad)
        begin
            sum       = 0;
            last_tbin = tt;
        end
        // Decay once per missing time bin, stop under 1.625 ADC
        while (last_tbin + 1 < tt)
        begin
            sum = (sum * longint'(cfg_slope)) >> 16;
            last_tbin++;
            if (sum < SUM_THRESHOLD)
            begin
                sum = 0;
                break;
            end
        end
        gain = (longint'(cfg_amp) * (longint'(65536) - longint'(cfg_slope))) >> 16;
        corr = (gain * sum) >> 20;
        if (cfg_neg)
            value = longint'(q) - longint'(corr);
        else
            value = longint'(q) + longint'(corr);
        if (value > 32767)
            value = 32767;
        else if (value < -32768)
            value = -32768;
        // Accumulate the raw charge with saturation, then decay once
        sum = sum + (longint'(q) << 4);
        if (sum > SUM_CEILING)
            sum = SUM_CEILING;
        sum       = (sum * longint'(cfg_slope)) >> 16;
        tail_sum  = sum;
        pad_open  = 1'b1;
        last_row  = r;
        last_pad  = p;
        last_tbin = tt;
        return value[OUT_W-1:0];
    endfunction

    function automatic logic [CHARGE_BITS-1:0] draw_charge();
        int roll;
        roll = $urandom_range(99);
        if (roll < 25)
            return CHARGE_BITS'($urandom_range(0, 15));
        else if (roll < 35)
            return CHARGE_BITS'(CHARGE_MAX);
        return CHARGE_BITS'($urandom_range(0, CHARGE_MAX));
    endfunction

    function automatic void add_row(input bit rc, input logic [GAIN_W-1:0] a,
                                    input logic [GAIN_W-1:0] s, input bit n,
                                    input logic [7:0] r, input logic [7:0] p,
                                    input logic [TIME_BITS-1:0] t,
                                    input logic [CHARGE_BITS-1:0] q,
                                    input bit k, input logic [OUT_W-1:0] res);
        vector_t v;
        v.reconfig = rc;
        v.amp      = a;
        v.slope    = s;
        v.neg      = n;
        v.row      = r;
        v.pad      = p;
        v.tbin     = t;
        v.charge   = q;
        v.known    = k;
        v.result   = res;
        vectors.push_back(v);
    endfunction

    // Offer one sample, hold it until the transfer, then queue its expected result
    task automatic send_sample(input logic [7:0] r, input logic [7:0] p,
                               input logic [TIME_BITS-1:0] t,
                               input logic [CHARGE_BITS-1:0] q,
                               input bit known, input logic [OUT_W-1:0] typed);
        logic [OUT_W-1:0] predicted;
        while (!steady_run && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(DATA_W - 16 - TIME_BITS - CHARGE_BITS){1'b0}}, q, t, p, r};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = predict_corrected(r, p, t, q);
        pending_corrected.push_back(known ? typed : predicted);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_AMP_GAIN:      cfg_amp   = value;
            REG_TAIL_SLOPE:    cfg_slope = value;
            REG_SIGN_NEGATIVE: cfg_neg   = value[0];
            default:           ;
        endcase
    endtask

    // Drain the block, then rewrite every register
    task automatic program_block(input logic [GAIN_W-1:0] a, input logic [GAIN_W-1:0] s,
                                 input bit n);
        s_axis_tvalid <= 1'b0;
        while (pending_corrected.size() != 0)
            @(posedge clk);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));
        write_reg(REG_AMP_GAIN, a);
        write_reg(REG_TAIL_SLOPE, s);
        write_reg(REG_SIGN_NEGATIVE, {{(CFG_DATA_W-1){1'b0}}, n});
        cfg_valid <= 1'b0;
    endtask

    // Result side: check each transfer, stall at random, hold off once for a long stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_corrected.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected corrected_charge %0d with nothing pending",
                                 $signed(m_axis_tdata));
                end
                else
                begin
                    want_charge = pending_corrected.pop_front();
                    if (m_axis_tdata !== want_charge)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("corrected_charge mismatch: expected %0d, got %0d",
                                     $signed(want_charge), $signed(m_axis_tdata));
                    end
                end
            end
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= steady_run || ($urandom_range(99) >= 15);
        end
    end

    initial
    begin
        int              random_sent;
        int              next_phase_at;
        int              phase;
        int              burst_len;
        int              roll;
        int              delta;
        int unsigned     tcur;
        logic [7:0]      cur_row;
        logic [7:0]      cur_pad;

        // Known values on every input from time zero
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_AMP_GAIN;
        cfg_data      = '0;
        cfg_amp       = '0;
        cfg_slope     = '0;
        cfg_neg       = 1'b0;
        pad_open      = 1'b0;
        last_row      = '0;
        last_pad      = '0;
        last_tbin     = 0;
        tail_sum      = 0;
        mismatches    = 0;
        cycle_count   = 0;
        hold_request  = 1'b0;
        steady_run    = 1'b0;

        // Registers at reset values: no correction
        add_row(0, 0, 0, 0, 8'd0, 8'd0, 20'd0, 14'd0, 1, 16'd0);
        add_row(0, 0, 0, 0, 8'd0, 8'd0, 20'd1, 14'd16383, 1, 16'd16383);
        // Zero slope: the sum is gone after every sample
        add_row(1, 16'hFFFF, 16'h0000, 0, 8'd0, 8'd0, 20'd2, 14'd16383, 1, 16'd16383);
        add_row(0, 0, 0, 0, 8'd0, 8'd0, 20'd3, 14'd5, 1, 16'd5);
        // Half slope: new pad, repeated and falling time bins, long gap, new pad and row
        add_row(1, 16'hFFFF, 16'h8000, 0, 8'd1, 8'd2, 20'd100, 14'd16383, 1, 16'd16383);
        add_row(0, 0, 0, 0, 8'd1, 8'd2, 20'd101, 14'd16383, 0, 16'd0);
        add_row(0, 0, 0, 0, 8'd1, 8'd2, 20'd102, 14'd0, 0, 16'd0);
        add_row(0, 0, 0, 0, 8'd1, 8'd2, 20'd102, 14'd77, 0, 16'd0);
        add_row(0, 0, 0, 0, 8'd1, 8'd2, 20'd50, 14'd1000, 0, 16'd0);
        add_row(0, 0, 0, 0, 8'd1, 8'd2, 20'hFFFFF, 14'd16383, 0, 16'd0);
        add_row(0, 0, 0, 0, 8'd1, 8'd3, 20'd0, 14'd3, 1, 16'd3);
        add_row(0, 0, 0, 0, 8'd255, 8'd255, 20'hFFFFF, 14'd16383, 1, 16'd16383);
        // Full slope has no gain; build up a large sum
        add_row(1, 16'hFFFF, 16'hFFFF, 0, 8'd2, 8'd7, 20'd10, 14'd16383, 1, 16'd16383);
        add_row(0, 0, 0, 0, 8'd2, 8'd7, 20'd11, 14'd16383, 1, 16'd16383);
        add_row(0, 0, 0, 0, 8'd2, 8'd7, 20'd12, 14'd16383, 1, 16'd16383);
        add_row(0, 0, 0, 0, 8'd2, 8'd7, 20'd13, 14'd16383, 1, 16'd16383);
        add_row(0, 0, 0, 0, 8'd2, 8'd7, 20'd14, 14'd16383, 1, 16'd16383);
        add_row(0, 0, 0, 0, 8'd2, 8'd7, 20'd15, 14'd16383, 1, 16'd16383);
        // Switch to zero slope: the built sum saturates the output high
        add_row(1, 16'hFFFF, 16'h0000, 0, 8'd2, 8'd7, 20'd16, 14'd16383, 1, 16'h7FFF);
        add_row(1, 16'hFFFF, 16'hFFFF, 0, 8'd2, 8'd7, 20'd17, 14'd16383, 1, 16'd16383);
        add_row(0, 0, 0, 0, 8'd2, 8'd7, 20'd18, 14'd16383, 1, 16'd16383);
        add_row(0, 0, 0, 0, 8'd2, 8'd7, 20'd19, 14'd16383, 1, 16'd16383);
        add_row(0, 0, 0, 0, 8'd2, 8'd7, 20'd20, 14'd16383, 1, 16'd16383);
        add_row(0, 0, 0, 0, 8'd2, 8'd7, 20'd21, 14'd16383, 1, 16'd16383);
        // Subtracting the same kind of sum saturates low
        add_row(1, 16'hFFFF, 16'h0000, 1, 8'd2, 8'd7, 20'd22, 14'd0, 1, 16'h8000);
        add_row(1, 16'h1234, 16'hC000, 1, 8'd3, 8'd4, 20'd1000, 14'd500, 1, 16'd500);
        add_row(0, 0, 0, 0, 8'd3, 8'd4, 20'd1003, 14'd9000, 0, 16'd0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (vectors[i])
        begin
            if (vectors[i].reconfig)
                program_block(vectors[i].amp, vectors[i].slope, vectors[i].neg);
            send_sample(vectors[i].row, vectors[i].pad, vectors[i].tbin, vectors[i].charge,
                        vectors[i].known, vectors[i].result);
        end

        // Build a large sum on one pad, then read it out through full gain
        program_block(16'h0100, 16'hFFFF, 1'b0);
        for (int i = 0; i < SOAK_ITEMS; i++)
            send_sample(8'd9, 8'd9, TIME_BITS'(i), CHARGE_BITS'(CHARGE_MAX), 1'b0, '0);
        program_block(16'hFFFF, 16'h0000, 1'b1);
        send_sample(8'd9, 8'd9, TIME_BITS'(SOAK_ITEMS), 14'd0, 1'b0, '0);

        // Random part: mostly ordered pad runs, some out-of-order noise
        random_sent   = 0;
        next_phase_at = 0;
        phase         = 0;
        cur_row       = 8'd9;
        cur_pad       = 8'd9;
        tcur          = SOAK_ITEMS;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent >= next_phase_at)
            begin
                case (phase % 5)
                    0: program_block(16'hFFFF, 16'hF000, 1'b1);
                    1: program_block(GAIN_W'($urandom_range(0, 65535)),
                                     GAIN_W'($urandom_range(16'h8000, 16'hFFFF)),
                                     1'($urandom_range(0, 1)));
                    2: program_block(16'hFFFF, 16'h0000, 1'b0);
                    3: program_block(16'h0000, GAIN_W'($urandom_range(0, 65535)), 1'b1);
                    default: program_block(GAIN_W'($urandom_range(0, 65535)),
                                           GAIN_W'($urandom_range(0, 65535)),
                                           1'($urandom_range(0, 1)));
                endcase
                phase         = phase + 1;
                next_phase_at = next_phase_at + PHASE_ITEMS;
            end
            steady_run = (random_sent >= 200 && random_sent < 300);
            if (random_sent >= 400)
                hold_request = 1'b1;
            roll = $urandom_range(99);
            if (roll < 80)
            begin
                // Ordered run; now and then carry on the previous pad after a gap
                if ($urandom_range(9) != 0)
                begin
                    cur_row = 8'($urandom_range(0, 255));
                    cur_pad = 8'($urandom_range(0, 255));
                    tcur    = $urandom_range(0, TIME_MAX);
                end
                else if (tcur + 300 <= TIME_MAX)
                    tcur = tcur + $urandom_range(2, 300);
                burst_len = $urandom_range(1, 12);
                for (int i = 0; i < burst_len; i++)
                begin
                    send_sample(cur_row, cur_pad, TIME_BITS'(tcur), draw_charge(), 1'b0, '0);
                    random_sent = random_sent + 1;
                    roll = $urandom_range(99);
                    if (roll < 70)
                        delta = 1;
                    else if (roll < 90)
                        delta = $urandom_range(2, 6);
                    else
                        delta = $urandom_range(7, 300);
                    tcur = (tcur + delta > TIME_MAX) ? TIME_MAX : tcur + delta;
                end
            end
            else if (roll < 90)
            begin
                // Same pad stepping back in time
                delta = $urandom_range(0, 50);
                tcur  = (tcur > delta) ? tcur - delta : 0;
                send_sample(cur_row, cur_pad, TIME_BITS'(tcur), draw_charge(), 1'b0, '0);
                random_sent = random_sent + 1;
            end
            else
            begin
                send_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            TIME_BITS'($urandom_range(0, TIME_MAX)), draw_charge(),
                            1'b0, '0);
                random_sent = random_sent + 1;
            end
        end
        steady_run = 1'b0;

        // Drain and let any stray result show up
        s_axis_tvalid <= 1'b0;
        while (pending_corrected.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (mismatches == 0 && pending_corrected.size() == 0)
            $display("ion_tail_exponential_correction_test: PASS");
        else
            $display("ion_tail_exponential_correction_test: FAIL");
        $finish;
    end

endmodule
